// ===== src/xcde_pkg.sv =====
// Shared constants, entity tables and the byte class type of the XML character data extractor.
`default_nettype none

package xcde_pkg;

	// Markup and entity characters.
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_QUOT = 8'h22;

	// Entity names after the ampersand, including the closing semicolon.
	localparam int ENT_COUNT  = 5;
	localparam int ENT_MAX    = 5;
	localparam int HOLD_DEPTH = 4;

	localparam logic [7:0] ENT_TEXT [ENT_COUNT][ENT_MAX] = '{
		'{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
		'{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
		'{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}
	};
	localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
	localparam logic [7:0] ENT_RAW [ENT_COUNT] = '{CH_LT, CH_GT, CH_AMP, CH_APOS, CH_QUOT};

	// Class of a text byte, worked out once when the byte enters.
	typedef struct packed {
		logic       is_amp;
		logic       is_lt;
		logic       is_gt;
		logic [2:0] utf_extra;
	} xcde_cls_t;

	localparam int CLS_BITS = $bits(xcde_cls_t);

endpackage

`default_nettype wire

// ===== src/xcde_front.sv =====
// Input side: accepts text bytes, numbers them and classifies them for the queue.
`default_nettype none

module xcde_front import xcde_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	input  logic                  q_full,
	output logic                  push,
	output logic [7:0]            push_byte,
	output logic                  push_last,
	output logic [INDEX_BITS-1:0] push_idx,
	output xcde_cls_t             push_cls
);

	logic [INDEX_BITS-1:0] pos_q;
	logic [INDEX_BITS:0]   pos_inc;

	// Number of UTF-8 continuation bytes announced by a lead byte.
	function automatic logic [2:0] utf8_extra(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		if (b[7:5] == 3'b110) n = 3'd1;
		else if (b[7:4] == 4'b1110) n = 3'd2;
		else if (b[7:3] == 5'b11110) n = 3'd3;
		else if (b[7:2] == 6'b111110) n = 3'd4;
		else if (b[7:1] == 7'b1111110) n = 3'd5;
		return n;
	endfunction

	// A word enters whenever the queue has room.
	assign in_ready  = !q_full;
	assign push      = in_valid && !q_full;
	assign push_byte = in_byte;
	assign push_last = in_last;
	assign push_idx  = pos_q;

	// Classify the byte for the back end.
	always_comb begin
		push_cls.is_amp    = (in_byte == CH_AMP);
		push_cls.is_lt     = (in_byte == CH_LT);
		push_cls.is_gt     = (in_byte == CH_GT);
		push_cls.utf_extra = utf8_extra(in_byte);
	end

	// Source position, saturating, back to zero after the final byte of a text.
	assign pos_inc = {1'b0, pos_q} + {{INDEX_BITS{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (in_last) begin
				pos_q <= '0;
			end else if (pos_inc[INDEX_BITS]) begin
				pos_q <= '1;
			end else begin
				pos_q <= pos_inc[INDEX_BITS-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/xcde_fifo.sv =====
// Short word queue between the front end and the back end.
`default_nettype none

module xcde_fifo #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int DEPTH    = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_q;
	logic [PTR_BITS-1:0] rd_q;
	logic [PTR_BITS:0]   cnt_q;

	assign full      = (cnt_q == (PTR_BITS + 1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== src/xcde_back.sv =====
// Back end: tag stripping, entity decoding, UTF-8 copying, replay and result output.
`default_nettype none

module xcde_back import xcde_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_v,
	input  logic [7:0]            head_byte,
	input  logic                  head_last,
	input  logic [INDEX_BITS-1:0] head_idx,
	input  xcde_cls_t             head_cls,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic [15:0]           out_index,
	output logic                  out_term,
	output logic                  out_last
);

	typedef enum logic [2:0] {
		MODE_TEXT = 3'b001,
		MODE_TAG  = 3'b010,
		MODE_ENT  = 3'b100
	} mode_t;

	// Scanner state.
	mode_t                 mode_q, mode_n;
	logic [7:0]            buf_q [HOLD_DEPTH];
	logic                  buf_we;
	logic [2:0]            fill_q, fill_n;
	logic [INDEX_BITS-1:0] ent_start_q, ent_start_n;
	logic [2:0]            utf_left_q, utf_left_n;
	logic [INDEX_BITS-1:0] utf_lead_q, utf_lead_n;

	// Replay of held entity bytes.
	logic                  head_fed_q;
	logic [2:0]            rp_q, rp_n;
	logic [2:0]            rn_q, rn_n;
	logic [2:0]            rk_q, rk_n;
	logic [7:0]            rx_q, rx_n;
	xcde_cls_t             rx_cls_q, rx_cls_n;
	logic [INDEX_BITS-1:0] rbase_q, rbase_n;

	// Pending and output results.
	logic                  pend_v_q, pend_sealed_q, pend_term_q;
	logic [7:0]            pend_byte_q;
	logic [INDEX_BITS-1:0] pend_idx_q;
	logic                  out_v_q, out_term_q, out_last_q;
	logic [7:0]            out_byte_q;
	logic [15:0]           out_idx_q;
	logic [INDEX_BITS+15:0] pend_idx_ext;

	// Step control.
	logic                  replay_act;
	logic                  act_feed, act_replay, act_flush, act_term;
	logic [7:0]            fb;
	xcde_cls_t             fcls;
	logic [INDEX_BITS-1:0] fidx;
	logic [INDEX_BITS:0]   rep_sum, term_sum;
	logic [INDEX_BITS-1:0] rep_idx, term_len;
	logic                  hit_any;
	logic [2:0]            hit_sel;
	logic                  res_v, res_term;
	logic [7:0]            res_byte;
	logic [INDEX_BITS-1:0] res_idx;
	logic                  final_step, fire, out_free, pend_move;

	assign replay_act = (rp_q != rn_q);
	assign act_feed   = !head_fed_q;
	assign act_replay = head_fed_q && replay_act;
	assign act_flush  = head_fed_q && !replay_act && head_last && (mode_q == MODE_ENT);
	assign act_term   = head_fed_q && !replay_act && head_last && (mode_q != MODE_ENT);

	// Replayed bytes keep the positions that followed the ampersand.
	assign rep_sum  = {1'b0, rbase_q} + {{(INDEX_BITS-2){1'b0}}, rp_q}
		+ {{INDEX_BITS{1'b0}}, 1'b1};
	assign rep_idx  = rep_sum[INDEX_BITS] ? '1 : rep_sum[INDEX_BITS-1:0];
	assign term_sum = {1'b0, head_idx} + {{INDEX_BITS{1'b0}}, 1'b1};
	assign term_len = term_sum[INDEX_BITS] ? '1 : term_sum[INDEX_BITS-1:0];

	// Byte fed this step: the queue head, a held byte or the byte that broke the match.
	always_comb begin
		if (act_replay) begin
			if (rp_q == rk_q) begin
				fb   = rx_q;
				fcls = rx_cls_q;
			end else begin
				fb   = buf_q[rp_q[1:0]];
				fcls = '0;
			end
			fidx = rep_idx;
		end else begin
			fb   = head_byte;
			fcls = head_cls;
			fidx = head_idx;
		end
	end

	// Entity match against the held prefix; the first listed entity wins.
	always_comb begin
		logic pre_ok;
		hit_any = 1'b0;
		hit_sel = '0;
		for (int e = ENT_COUNT - 1; e >= 0; e--) begin
			pre_ok = 1'b1;
			for (int j = 0; j < HOLD_DEPTH; j++) begin
				if (3'(j) < fill_q && buf_q[j] != ENT_TEXT[e][j]) pre_ok = 1'b0;
			end
			if (ENT_LEN[e] > fill_q && ENT_TEXT[e][fill_q] == fb && pre_ok) begin
				hit_any = 1'b1;
				hit_sel = 3'(e);
			end
		end
	end

	// One scanner step.
	always_comb begin
		mode_n      = mode_q;
		fill_n      = fill_q;
		buf_we      = 1'b0;
		ent_start_n = ent_start_q;
		utf_left_n  = utf_left_q;
		utf_lead_n  = utf_lead_q;
		rp_n        = act_replay ? rp_q + 3'd1 : rp_q;
		rn_n        = rn_q;
		rk_n        = rk_q;
		rx_n        = rx_q;
		rx_cls_n    = rx_cls_q;
		rbase_n     = rbase_q;
		res_v       = 1'b0;
		res_byte    = fb;
		res_idx     = fidx;
		res_term    = 1'b0;
		if (act_term) begin
			// End of text: length word, then everything back to its reset values.
			res_v       = 1'b1;
			res_byte    = '0;
			res_idx     = term_len;
			res_term    = 1'b1;
			mode_n      = MODE_TEXT;
			fill_n      = '0;
			ent_start_n = '0;
			utf_left_n  = '0;
			utf_lead_n  = '0;
			rp_n        = '0;
			rn_n        = '0;
		end else if (act_flush) begin
			// Entity left open at end of text: pass the ampersand and replay the held bytes.
			res_v    = 1'b1;
			res_byte = CH_AMP;
			res_idx  = ent_start_q;
			rp_n     = '0;
			rk_n     = fill_q;
			rn_n     = fill_q;
			rbase_n  = ent_start_q;
			mode_n   = MODE_TEXT;
			fill_n   = '0;
		end else if (act_feed || act_replay) begin
			if (utf_left_q != '0) begin
				// UTF-8 continuation byte, copied verbatim at the lead position.
				res_v      = 1'b1;
				res_idx    = utf_lead_q;
				utf_left_n = utf_left_q - 3'd1;
			end else begin
				case (mode_q)
					MODE_TAG: begin
						if (fcls.is_gt) mode_n = MODE_TEXT;
					end
					MODE_ENT: begin
						if (!hit_any) begin
							res_v    = 1'b1;
							res_byte = CH_AMP;
							res_idx  = ent_start_q;
							rp_n     = '0;
							rk_n     = fill_q;
							rn_n     = fill_q + 3'd1;
							rx_n     = fb;
							rx_cls_n = fcls;
							rbase_n  = ent_start_q;
							mode_n   = MODE_TEXT;
							fill_n   = '0;
						end else if (ENT_LEN[hit_sel] == fill_q + 3'd1) begin
							res_v    = 1'b1;
							res_byte = ENT_RAW[hit_sel];
							res_idx  = ent_start_q;
							mode_n   = MODE_TEXT;
							fill_n   = '0;
						end else if (fill_q < 3'(HOLD_DEPTH)) begin
							buf_we = 1'b1;
							fill_n = fill_q + 3'd1;
						end
					end
					default: begin
						if (fcls.is_amp) begin
							mode_n      = MODE_ENT;
							fill_n      = '0;
							ent_start_n = fidx;
						end else if (fcls.is_lt) begin
							mode_n = MODE_TAG;
						end else begin
							res_v = 1'b1;
							if (fcls.utf_extra != '0) begin
								utf_left_n = fcls.utf_extra;
								utf_lead_n = fidx;
							end
						end
					end
				endcase
			end
		end
	end

	// The word is done once no replay remains and, at end of text, the length went out.
	assign final_step = act_term || (!head_last && (rp_n == rn_n));
	assign out_free   = !out_v_q || out_ready;
	assign fire       = head_v && (!res_v || !pend_v_q || out_free);
	assign pop        = fire && final_step;
	assign pend_move  = pend_v_q && out_free && (pend_sealed_q || (fire && res_v));

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_TEXT;
			fill_q        <= '0;
			utf_left_q    <= '0;
			head_fed_q    <= 1'b0;
			rp_q          <= '0;
			rn_q          <= '0;
			pend_v_q      <= 1'b0;
			pend_sealed_q <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			if (fire) begin
				mode_q     <= mode_n;
				fill_q     <= fill_n;
				utf_left_q <= utf_left_n;
				head_fed_q <= !final_step;
				rp_q       <= rp_n;
				rn_q       <= rn_n;
			end
			if (fire && res_v) begin
				pend_v_q      <= 1'b1;
				pend_sealed_q <= final_step;
			end else if (pend_move) begin
				pend_v_q      <= 1'b0;
				pend_sealed_q <= 1'b0;
			end else if (fire && final_step && pend_v_q) begin
				pend_sealed_q <= 1'b1;
			end
			if (pend_move) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (fire) begin
			ent_start_q <= ent_start_n;
			utf_lead_q  <= utf_lead_n;
			rk_q        <= rk_n;
			rx_q        <= rx_n;
			rx_cls_q    <= rx_cls_n;
			rbase_q     <= rbase_n;
			if (buf_we) buf_q[fill_q[1:0]] <= fb;
		end
		if (fire && res_v) begin
			pend_byte_q <= res_byte;
			pend_idx_q  <= res_idx;
			pend_term_q <= res_term;
		end
		if (pend_move) begin
			out_byte_q <= pend_byte_q;
			out_idx_q  <= pend_idx_ext[15:0];
			out_term_q <= pend_term_q;
			out_last_q <= pend_sealed_q;
		end
	end

	assign pend_idx_ext = {16'b0, pend_idx_q};

	assign out_valid = out_v_q;
	assign out_byte  = out_byte_q;
	assign out_index = out_idx_q;
	assign out_term  = out_term_q;
	assign out_last  = out_last_q;

	// A sealed pending word must exist.
	a_sealed_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pend_sealed_q |-> pend_v_q)
		else $error("sealed pending word without a valid word");

	// Replay pointer stays within the replay count, which covers four held bytes and one more.
	a_replay_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rp_q <= rn_q) && (rn_q <= 3'd5))
		else $error("replay pointer out of range");

	// The entity hold buffer never overfills.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'(HOLD_DEPTH))
		else $error("entity fill out of range");

	// A word that has been fed stays at the queue head until it is popped.
	a_fed_head: assert property (@(posedge clk) disable iff (!arst_n)
		head_fed_q |-> head_v)
		else $error("fed word vanished from the queue head");

	// An unsealed pending word only leaves when a newer word of the same run replaces it.
	a_pend_leave: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && !pend_sealed_q && !(fire && res_v)) |=> pend_v_q)
		else $error("pending word left before its run ended");

endmodule

`default_nettype wire

// ===== src/xml_char_data_extractor.sv =====
// Top level of the XML character data extractor: front end, queue and back end.
//
// Usage:
//   Slave stream: one text byte per word in s_axis_tdata, s_axis_tlast on the final byte
//   of a text. Master stream: one character data byte per word, with the source position
//   where its character begins; m_axis_tuser marks the end-of-text word carrying the total
//   length, and m_axis_tlast marks the last word caused by an input byte.
//   Tags are dropped, the five predefined entities become one byte at the ampersand
//   position, and a UTF-8 sequence is copied whole at the lead byte position.
// Path: a taken plain byte passes the queue, the pending register and the output register
//   before m_axis_tvalid rises.
// Throughput: one byte per cycle while no replay runs and the master side is ready. An
//   ampersand that starts no known entity replays the held bytes and the breaking byte
//   through the back end; the end of a text also sends the length word through it, plus a
//   replay when an entity is left open. The back end step loop feeds one byte per cycle.
// Reset: clears the queue, the scanner and the source position; a new text starts at 0.
// Stall: with the master side stalled, one result waits in the output register and one
//   in the pending register; the four-word queue then fills and s_axis_tready falls.
`default_nettype none

module xml_char_data_extractor import xcde_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // stream_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] char_byte, [23:8] source_index
	output logic        m_axis_tuser,   // is_terminator
	output logic        m_axis_tlast    // run_last
);

	localparam int Q_WIDTH = INDEX_BITS + 1 + CLS_BITS + 8;

	logic                  q_push, q_full, q_pop, q_nempty;
	logic [7:0]            push_byte;
	logic                  push_last;
	logic [INDEX_BITS-1:0] push_idx;
	xcde_cls_t             push_cls;
	logic [Q_WIDTH-1:0]    q_in, q_out;
	logic [7:0]            head_byte;
	logic                  head_last;
	logic [INDEX_BITS-1:0] head_idx;
	xcde_cls_t             head_cls;
	logic [7:0]            res_byte;
	logic [15:0]           res_index;

	xcde_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_full    (q_full),
		.push      (q_push),
		.push_byte (push_byte),
		.push_last (push_last),
		.push_idx  (push_idx),
		.push_cls  (push_cls)
	);

	// Queue word: position, last flag, class and byte.
	assign q_in = {push_idx, push_last, push_cls, push_byte};

	xcde_fifo #(.WIDTH(Q_WIDTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.not_empty (q_nempty)
	);

	assign {head_idx, head_last, head_cls, head_byte} = q_out;

	xcde_back #(.INDEX_BITS(INDEX_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_v    (q_nempty),
		.head_byte (head_byte),
		.head_last (head_last),
		.head_idx  (head_idx),
		.head_cls  (head_cls),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (res_byte),
		.out_index (res_index),
		.out_term  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {res_index, res_byte};

endmodule

`default_nettype wire

// ===== dv/tb_xml_char_data_extractor.sv =====
// Self-checking testbench of the XML character data extractor: stream driver, sink and scoreboard.
`default_nettype none

module tb_xml_char_data_extractor;
	import xcde_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     INDEX_BITS = 16;
	localparam longint IDX_MAX    = (longint'(1) << INDEX_BITS) - 1;
	localparam int     MAX_WORDS  = 7;

	// Scanner modes of the predictor.
	typedef enum logic [1:0] {
		SCAN_TEXT,
		SCAN_TAG,
		SCAN_ENTITY
	} scan_mode_t;

	// Predicts the character data words of each text byte and checks the words that come out.
	class char_data_board;
		scan_mode_t  mode;
		logic [7:0]  held [4];
		int          held_cnt;
		longint      amp_pos;
		longint      next_pos;
		int          cont_left;
		longint      lead_pos;
		logic [7:0]  replay_byte [$];
		longint      replay_pos [$];
		logic [25:0] step_words [$];
		logic [25:0] expected_words [$];
		logic [7:0]  ent_chr [5][5];
		int          ent_len [5];
		logic [7:0]  ent_raw [5];
		int          fails;

		function new();
			// Names after the ampersand: lt; gt; amp; apos; quot;
			ent_chr = '{
				'{"l", "t", ";", 8'h00, 8'h00},
				'{"g", "t", ";", 8'h00, 8'h00},
				'{"a", "m", "p", ";", 8'h00},
				'{"a", "p", "o", "s", ";"},
				'{"q", "u", "o", "t", ";"}
			};
			ent_len = '{3, 3, 4, 5, 5};
			ent_raw = '{CH_LT, CH_GT, CH_AMP, CH_APOS, CH_QUOT};
			fails = 0;
			clear();
		endfunction

		function void clear();
			mode = SCAN_TEXT;
			held_cnt = 0;
			amp_pos = 0;
			next_pos = 0;
			cont_left = 0;
			lead_pos = 0;
			replay_byte.delete();
			replay_pos.delete();
		endfunction

		function longint sat_add(longint a, longint b);
			return (a + b > IDX_MAX) ? IDX_MAX : a + b;
		endfunction

		function void emit(logic [7:0] b, longint p, logic term);
			if (step_words.size() < MAX_WORDS)
				step_words.push_back({1'b0, term, p[15:0], b});
		endfunction

		// Number of continuation bytes announced by a UTF-8 lead byte.
		function int cont_count(logic [7:0] b);
			if (b >= 8'hC0 && b <= 8'hDF) return 1;
			if (b >= 8'hE0 && b <= 8'hEF) return 2;
			if (b >= 8'hF0 && b <= 8'hF7) return 3;
			if (b >= 8'hF8 && b <= 8'hFB) return 4;
			if (b >= 8'hFC && b <= 8'hFD) return 5;
			return 0;
		endfunction

		// Put the held entity bytes, and optionally the breaking byte, in front of the replay queue.
		function void replay_held(bit with_extra, logic [7:0] extra);
			int k;
			int i;
			k = (held_cnt > 4) ? 4 : held_cnt;
			if (with_extra) begin
				replay_byte.push_front(extra);
				replay_pos.push_front(sat_add(amp_pos, k + 1));
			end
			for (i = k - 1; i >= 0; i--) begin
				replay_byte.push_front(held[i]);
				replay_pos.push_front(sat_add(amp_pos, i + 1));
			end
			mode = SCAN_TEXT;
			held_cnt = 0;
		endfunction

		function void scan_byte(logic [7:0] b, longint p);
			int  k;
			int  hit;
			int  e;
			int  j;
			bit  same;
			// A UTF-8 sequence is copied whole, whatever its bytes are.
			if (cont_left > 0) begin
				emit(b, lead_pos, 1'b0);
				cont_left--;
				return;
			end
			if (mode == SCAN_TAG) begin
				if (b == CH_GT)
					mode = SCAN_TEXT;
				return;
			end
			if (mode == SCAN_ENTITY) begin
				k = (held_cnt > 4) ? 4 : held_cnt;
				hit = -1;
				for (e = 0; e < 5 && hit < 0; e++) begin
					same = (ent_len[e] > k) && (ent_chr[e][k] == b);
					for (j = 0; j < k; j++)
						if (held[j] != ent_chr[e][j])
							same = 1'b0;
					if (same)
						hit = e;
				end
				if (hit < 0) begin
					emit(CH_AMP, amp_pos, 1'b0);
					replay_held(1'b1, b);
				end else if (ent_len[hit] == k + 1) begin
					emit(ent_raw[hit], amp_pos, 1'b0);
					mode = SCAN_TEXT;
					held_cnt = 0;
				end else if (k < 4) begin
					held[k] = b;
					held_cnt = k + 1;
				end
				return;
			end
			if (b == CH_AMP) begin
				mode = SCAN_ENTITY;
				held_cnt = 0;
				amp_pos = p;
			end else if (b == CH_LT) begin
				mode = SCAN_TAG;
			end else begin
				emit(b, p, 1'b0);
				if (cont_count(b) > 0) begin
					cont_left = cont_count(b);
					lead_pos = p;
				end
			end
		endfunction

		// Note one accepted text byte and queue the words it causes.
		function void take_text_byte(logic [7:0] b, logic fin);
			logic [7:0]  qb;
			longint      qp;
			logic [25:0] w;
			step_words.delete();
			replay_byte.delete();
			replay_pos.delete();
			replay_byte.push_back(b);
			replay_pos.push_back(next_pos);
			next_pos = sat_add(next_pos, 1);
			while (1) begin
				if (replay_byte.size() > 0) begin
					qb = replay_byte.pop_front();
					qp = replay_pos.pop_front();
					scan_byte(qb, qp);
				end else if (fin && mode == SCAN_ENTITY) begin
					// An entity left open at the end of the text passes through.
					emit(CH_AMP, amp_pos, 1'b0);
					replay_held(1'b0, 8'h00);
				end else begin
					break;
				end
			end
			if (fin) begin
				emit(8'h00, next_pos, 1'b1);
				clear();
			end
			if (step_words.size() > 0) begin
				w = step_words.pop_back();
				w[25] = 1'b1;
				step_words.push_back(w);
			end
			while (step_words.size() > 0)
				expected_words.push_back(step_words.pop_front());
		endfunction

		// Compare one received word with the oldest expected one.
		function void check_char_word(logic [7:0] c, logic [15:0] idx, logic term, logic last);
			logic [25:0] w;
			if (expected_words.size() == 0) begin
				$error("unexpected word: char_byte %0h source_index %0d is_terminator %0b",
					c, idx, term);
				fails++;
				return;
			end
			w = expected_words.pop_front();
			if (w[7:0] != c) begin
				$error("char_byte: expected %0h, actual %0h", w[7:0], c);
				fails++;
			end
			if (w[23:8] != idx) begin
				$error("source_index: expected %0d, actual %0d", w[23:8], idx);
				fails++;
			end
			if (w[24] != term) begin
				$error("is_terminator: expected %0b, actual %0b", w[24], term);
				fails++;
			end
			if (w[25] != last) begin
				$error("run_last: expected %0b, actual %0b", w[25], last);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tlast;   // stream_end
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [7:0] char_byte, [23:8] source_index
	logic        m_axis_tuser;   // is_terminator
	logic        m_axis_tlast;   // run_last

	char_data_board board;
	bit             idle_off = 1'b0;
	logic [7:0]     text_bytes [$];

	xml_char_data_extractor #(
		.INDEX_BITS(INDEX_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Offer one text byte after a random gap and hold it until the block takes the word.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
		board.take_text_byte(b, fin);
	endtask

	// Send the buffered text, marking its final byte as the end of the stream.
	task automatic send_text();
		int i;
		for (i = 0; i < text_bytes.size(); i++)
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
		text_bytes.delete();
	endtask

	task automatic add_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endtask

	// Hold the input idle until every expected word has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Build a random text from plain bytes, entities, broken entities, tags and UTF-8 runs.
	task automatic build_random_text(output int counted);
		int         e;
		int         n;
		int         cut;
		logic [7:0] b;
		counted = 0;
		text_bytes.delete();
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 7))
				0, 1: begin
					text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
					counted++;
				end
				2: begin
					e = $urandom_range(0, 4);
					text_bytes.push_back(CH_AMP);
					for (n = 0; n < board.ent_len[e]; n++)
						text_bytes.push_back(board.ent_chr[e][n]);
					counted += board.ent_len[e] + 1;
				end
				3, 7: begin
					// Entity prefix, broken by a random byte or left for what follows.
					e = $urandom_range(0, 4);
					cut = $urandom_range(0, board.ent_len[e] - 1);
					text_bytes.push_back(CH_AMP);
					for (n = 0; n < cut; n++)
						text_bytes.push_back(board.ent_chr[e][n]);
					counted += cut + 1;
					if ($urandom_range(0, 1) == 0) begin
						text_bytes.push_back(8'($urandom_range(0, 255)));
						counted++;
					end
				end
				4: begin
					n = $urandom_range(0, 4);
					text_bytes.push_back(CH_LT);
					repeat (n) begin
						b = 8'($urandom_range(0, 255));
						text_bytes.push_back((b == CH_GT) ? 8'h41 : b);
					end
					text_bytes.push_back(CH_GT);
					counted += n + 2;
				end
				5: begin
					n = $urandom_range(1, 5);
					case (n)
						1: b = 8'($urandom_range(8'hC0, 8'hDF));
						2: b = 8'($urandom_range(8'hE0, 8'hEF));
						3: b = 8'($urandom_range(8'hF0, 8'hF7));
						4: b = 8'($urandom_range(8'hF8, 8'hFB));
						default: b = 8'($urandom_range(8'hFC, 8'hFD));
					endcase
					text_bytes.push_back(b);
					repeat (n) begin
						if ($urandom_range(0, 3) == 0)
							text_bytes.push_back(8'($urandom_range(0, 255)));
						else
							text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
					end
					counted += n + 1;
				end
				default: begin
					text_bytes.push_back(8'($urandom_range(0, 255)));
					counted++;
				end
			endcase
		end
	endtask

	// Stimulus: directed texts, then random texts.
	initial begin : stimulus
		int counted;
		int got;
		int wait_cnt;
		board = new();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		s_axis_tlast <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Longest entity, broken entity, zero byte, continuation bytes that look like
		// markup, top byte value, a tag and an entity left open at the end of the text.
		add_str("&apos;&ax");
		text_bytes.push_back(8'h00);
		text_bytes.push_back(8'hE2);
		add_str("<&");
		text_bytes.push_back(8'hFF);
		add_str("<b>&am");
		send_text();
		// UTF-8 sequence cut by the end of the text.
		text_bytes.push_back(8'hF0);
		text_bytes.push_back(8'h9F);
		send_text();
		// Unclosed tag swallows the rest.
		add_str("<x");
		send_text();
		drain();

		got = 0;
		while (got < 88) begin
			build_random_text(counted);
			got += counted;
			idle_off = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 5) == 0)
				drain();
			send_text();
		end

		s_axis_tvalid <= 1'b0;
		wait_cnt = 0;
		while (board.expected_words.size() != 0 && wait_cnt < 5000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (10) @(posedge clk);
		if (board.expected_words.size() != 0) begin
			$error("%0d expected words never came out", board.expected_words.size());
			board.fails++;
		end
		if (board.fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Output sink: random stall before each word, then check the word when it is taken.
	initial begin : sink
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_off ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			board.check_char_word(m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tuser,
				m_axis_tlast);
		end
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#(20_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== xml_char_data_extractor.f =====
src/xcde_pkg.sv
src/xcde_front.sv
src/xcde_fifo.sv
src/xcde_back.sv
src/xml_char_data_extractor.sv
dv/tb_xml_char_data_extractor.sv
